// ===== src/plstr_pkg.sv =====
// ----------------------------------------------------------------------------
// plstr_pkg
// shared constants, command and status codes for the positional list store
// ----------------------------------------------------------------------------
package plstr_pkg;

	localparam int CAPACITY = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 11;
	localparam int POS_W    = 11;
	localparam int CMP_W    = 12;

	typedef logic [2:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_INS_FRONT = 3'd0;
	localparam cmd_t CMD_INS_BACK  = 3'd1;
	localparam cmd_t CMD_INS_AT    = 3'd2;
	localparam cmd_t CMD_READ_ALL  = 3'd3;
	localparam cmd_t CMD_UPDATE    = 3'd4;
	localparam cmd_t CMD_DEL_FRONT = 3'd5;
	localparam cmd_t CMD_DEL_BACK  = 3'd6;
	localparam cmd_t CMD_DEL_AT    = 3'd7;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_EMPTY  = 2'd1;
	localparam status_t ST_BADPOS = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

endpackage

// ===== src/plstr_ram.sv =====
// ----------------------------------------------------------------------------
// plstr_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module plstr_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// bounded ordered list of signed values with positional insert and delete
// ----------------------------------------------------------------------------
// The list lives in slots 0 .. length-1 of a CAPACITY-entry ram in list
// order. One request is taken at a time: in_ready is high only while the
// sequencer is idle. Insert and delete open or close a gap by walking the
// entries behind the position with one shared index counter, one ram read
// followed by one ram write per moved entry. At most CAPACITY-1 entries
// move in an insert or delete. Read all loads one result per entry, with
// last on the final one; every other request gives one result. Update and
// failed requests load their result without a walk. in_ready is high
// again in the cycle right after the last result is loaded. The result
// sits in an output register, so the next request can be taken while it
// waits; a result that finds the output register still full holds the
// sequencer until the receiver takes the waiting one. The ram needs no
// clearing pass: only written slots are read.
// ----------------------------------------------------------------------------
module positional_list_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          cmd,
	input  logic signed [plstr_pkg::POS_W-1:0]  position,
	input  logic signed [plstr_pkg::VAL_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic signed [plstr_pkg::VAL_W-1:0]  entry_value,
	output logic                                entry_valid,
	output logic                                last,
	output logic [5:0]                          length_now
);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_OPEN     = 3'd1;
	localparam logic [2:0] S_OPEN_WR  = 3'd2;
	localparam logic [2:0] S_CLOSE    = 3'd3;
	localparam logic [2:0] S_CLOSE_WR = 3'd4;
	localparam logic [2:0] S_RD_ISSUE = 3'd5;
	localparam logic [2:0] S_RD_WAIT  = 3'd6;
	localparam logic [2:0] S_RESP     = 3'd7;

	logic [2:0]                        state_q, state_d;
	logic [plstr_pkg::CNT_W-1:0]       count_q, count_d;
	logic [plstr_pkg::CNT_W-1:0]       idx_q, idx_d;
	logic [plstr_pkg::CNT_W-1:0]       at_q, at_d;
	logic [plstr_pkg::VAL_W-1:0]       val_q, val_d;
	plstr_pkg::status_t                res_st_q, res_st_d;

	// output register
	logic                              ov_q, ov_d;
	plstr_pkg::status_t                ost_q, ost_d;
	logic [plstr_pkg::VAL_W-1:0]       oval_q, oval_d;
	logic                              oev_q, oev_d;
	logic                              olast_q, olast_d;
	logic [5:0]                        olen_q, olen_d;

	// ram port
	logic                              ram_we;
	logic [plstr_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
	logic [plstr_pkg::VAL_W-1:0]       ram_wdata, ram_rdata;

	// shared index unit
	logic [plstr_pkg::CNT_W-1:0]       idx_inc, idx_dec;
	logic [plstr_pkg::CNT_W-1:0]       pos_idx;

	logic                              accept;
	logic                              can_load;
	logic                              is_empty, is_full;
	logic                              pos_ge1, pos_ok_ins, pos_ok_upd;
	logic [plstr_pkg::CMP_W-1:0]       pos_ext, cnt_ext;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign can_load = !ov_q || out_ready;

	assign idx_inc  = plstr_pkg::CNT_W'(idx_q + plstr_pkg::CNT_W'(1));
	assign idx_dec  = plstr_pkg::CNT_W'(idx_q - plstr_pkg::CNT_W'(1));

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == plstr_pkg::CNT_W'(plstr_pkg::CAPACITY));

	// position range checks on the signed request position
	assign pos_ext    = plstr_pkg::CMP_W'(position[plstr_pkg::POS_W-2:0]);
	assign cnt_ext    = plstr_pkg::CMP_W'(count_q);
	assign pos_ge1    = !position[plstr_pkg::POS_W-1] && (pos_ext != '0);
	assign pos_ok_ins = pos_ge1 && (pos_ext <= cnt_ext + plstr_pkg::CMP_W'(1));
	assign pos_ok_upd = pos_ge1 && (pos_ext <= cnt_ext);
	assign pos_idx    = plstr_pkg::CNT_W'(pos_ext - plstr_pkg::CMP_W'(1));

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		at_d      = at_q;
		val_d     = val_q;
		res_st_d  = res_st_q;
		ov_d      = ov_q && !out_ready;
		ost_d     = ost_q;
		oval_d    = oval_q;
		oev_d     = oev_q;
		olast_d   = olast_q;
		olen_d    = olen_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[plstr_pkg::ADDR_W-1:0];
		ram_wdata = val_q;
		ram_raddr = idx_q[plstr_pkg::ADDR_W-1:0];

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_d    = value;
					res_st_d = plstr_pkg::ST_OK;
					state_d  = S_RESP;
					case (cmd)
						plstr_pkg::CMD_INS_FRONT, plstr_pkg::CMD_INS_BACK: begin
							if (is_full) begin
								res_st_d = plstr_pkg::ST_FULL;
							end else begin
								at_d    = (cmd == plstr_pkg::CMD_INS_FRONT) ? '0 : count_q;
								idx_d   = count_q;
								state_d = S_OPEN;
							end
						end
						plstr_pkg::CMD_INS_AT: begin
							if (is_empty) begin
								res_st_d = plstr_pkg::ST_EMPTY;
							end else if (!pos_ok_ins) begin
								res_st_d = plstr_pkg::ST_BADPOS;
							end else if (is_full) begin
								res_st_d = plstr_pkg::ST_FULL;
							end else begin
								at_d    = pos_idx;
								idx_d   = count_q;
								state_d = S_OPEN;
							end
						end
						plstr_pkg::CMD_READ_ALL: begin
							if (is_empty) begin
								res_st_d = plstr_pkg::ST_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = S_RD_ISSUE;
							end
						end
						plstr_pkg::CMD_UPDATE: begin
							if (is_empty) begin
								res_st_d = plstr_pkg::ST_EMPTY;
							end else if (!pos_ok_upd) begin
								res_st_d = plstr_pkg::ST_BADPOS;
							end else begin
								// in-place write, no walk needed
								ram_we    = 1'b1;
								ram_waddr = pos_idx[plstr_pkg::ADDR_W-1:0];
								ram_wdata = value;
							end
						end
						plstr_pkg::CMD_DEL_FRONT, plstr_pkg::CMD_DEL_BACK: begin
							if (is_empty) begin
								res_st_d = plstr_pkg::ST_EMPTY;
							end else begin
								idx_d   = (cmd == plstr_pkg::CMD_DEL_FRONT) ? '0 :
									plstr_pkg::CNT_W'(count_q - plstr_pkg::CNT_W'(1));
								state_d = S_CLOSE;
							end
						end
						plstr_pkg::CMD_DEL_AT: begin
							if (is_empty) begin
								res_st_d = plstr_pkg::ST_EMPTY;
							end else if (!pos_ok_upd) begin
								res_st_d = plstr_pkg::ST_BADPOS;
							end else begin
								idx_d   = pos_idx;
								state_d = S_CLOSE;
							end
						end
						default: begin
							res_st_d = plstr_pkg::ST_OK;
						end
					endcase
				end
			end
			// open a gap: move entries down from the tail toward the insert slot
			S_OPEN: begin
				if (idx_q > at_q) begin
					ram_raddr = idx_dec[plstr_pkg::ADDR_W-1:0];
					state_d   = S_OPEN_WR;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = at_q[plstr_pkg::ADDR_W-1:0];
					ram_wdata = val_q;
					count_d   = plstr_pkg::CNT_W'(count_q + plstr_pkg::CNT_W'(1));
					state_d   = S_RESP;
				end
			end
			S_OPEN_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				idx_d     = idx_dec;
				state_d   = S_OPEN;
			end
			// close a gap: pull following entries up by one slot
			S_CLOSE: begin
				if (idx_inc < count_q) begin
					ram_raddr = idx_inc[plstr_pkg::ADDR_W-1:0];
					state_d   = S_CLOSE_WR;
				end else begin
					count_d = plstr_pkg::CNT_W'(count_q - plstr_pkg::CNT_W'(1));
					state_d = S_RESP;
				end
			end
			S_CLOSE_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				idx_d     = idx_inc;
				state_d   = S_CLOSE;
			end
			// read out: address held on idx, data arrives in the next cycle
			S_RD_ISSUE: begin
				state_d = S_RD_WAIT;
			end
			S_RD_WAIT: begin
				if (can_load) begin
					ov_d    = 1'b1;
					ost_d   = plstr_pkg::ST_OK;
					oval_d  = ram_rdata;
					oev_d   = 1'b1;
					olast_d = (idx_inc == count_q);
					olen_d  = 6'(count_q);
					idx_d   = idx_inc;
					state_d = (idx_inc == count_q) ? S_IDLE : S_RD_ISSUE;
				end
			end
			S_RESP: begin
				if (can_load) begin
					ov_d    = 1'b1;
					ost_d   = res_st_q;
					oval_d  = '0;
					oev_d   = 1'b0;
					olast_d = 1'b1;
					olen_d  = 6'(count_q);
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ov_q    <= ov_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		at_q     <= at_d;
		val_q    <= val_d;
		res_st_q <= res_st_d;
		ost_q    <= ost_d;
		oval_q   <= oval_d;
		oev_q    <= oev_d;
		olast_q  <= olast_d;
		olen_q   <= olen_d;
	end

	plstr_ram #(
		.WIDTH (plstr_pkg::VAL_W),
		.DEPTH (plstr_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid   = ov_q;
	assign status      = ost_q;
	assign entry_value = oval_q;
	assign entry_valid = oev_q;
	assign last        = olast_q;
	assign length_now  = olen_q;

	// list length never exceeds the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= plstr_pkg::CNT_W'(plstr_pkg::CAPACITY))
		else $error("list length beyond capacity");

	// length moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == plstr_pkg::CNT_W'($past(count_q) + plstr_pkg::CNT_W'(1)) ||
		 count_q == plstr_pkg::CNT_W'($past(count_q) - plstr_pkg::CNT_W'(1))))
		else $error("list length jumped");

	// read-out only walks live slots
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_WAIT) |-> (idx_q < count_q))
		else $error("read index past list end");

	// an entry on the output always carries ok status
	a_entry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && oev_q) |-> (ost_q == plstr_pkg::ST_OK))
		else $error("entry with failing status");

endmodule
